// ===== design/sse_pkg.sv =====
// sse_pkg: shared sizes, operation and status codes and cell control types
// for the sorted set engine
// no dependencies
`default_nettype none

package sse_pkg;

    // store geometry
    localparam int CAPACITY   = 16;
    localparam int VALUE_BITS = 32;

    // fixed field widths at the ports
    localparam int MODE_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // internal widths
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

    // stream data widths, whole bytes
    localparam int S_DATA_W = ((VALUE_W + POS_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        OP_INSERT  = 2'd0,
        OP_DELETE  = 2'd1,
        OP_REVERSE = 2'd2,
        OP_READ    = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_DUP    = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    typedef logic signed [VALUE_BITS-1:0] t_value;

    // operands seen by every cell
    typedef struct packed {
        t_value           value;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] at;
    } t_cell_op;

    // write strobes to every cell
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_wr;

endpackage

`default_nettype wire

// ===== design/sse_cell.sv =====
// sse_cell: one slot of the sorted row, compares, shifts and passes on reads
// depends on sse_pkg
`default_nettype none

module sse_cell
    import sse_pkg::*;
(
    input  wire              i_clk,
    input  wire  [IDX_W-1:0] i_index,
    input  wire  t_cell_op   i_op,
    input  wire  t_cell_wr   i_wr,
    input  wire  t_value     i_left_entry,
    input  wire              i_left_ge,
    input  wire  t_value     i_right_entry,
    input  wire  t_value     i_acc,
    output t_value           o_entry,
    output logic             o_ge,
    output logic             o_eq,
    output t_value           o_acc
);

    t_value r_entry;
    t_value n_entry;
    logic   w_valid;
    logic   w_hit;

    assign w_valid = CNT_W'(i_index) < i_op.count;
    assign w_hit   = (i_index == i_op.at);

    // ge marks the insert slot and everything above it
    assign o_ge    = !w_valid || (r_entry >= i_op.value);
    assign o_eq    = w_valid && (r_entry == i_op.value);
    assign o_entry = r_entry;
    assign o_acc   = i_acc | (w_hit ? r_entry : '0);

    always_comb begin
        n_entry = r_entry;
        if (i_wr.ins) begin
            if (i_left_ge) begin
                n_entry = i_left_entry;
            end else if (o_ge) begin
                n_entry = i_op.value;
            end
        end else if (i_wr.del) begin
            if (i_index >= i_op.at) begin
                n_entry = i_right_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

// ===== design/sse_chain.sv =====
// sse_chain: the row of slots with neighbour links and the read pass-along
// depends on sse_pkg and sse_cell
`default_nettype none

module sse_chain
    import sse_pkg::*;
(
    input  wire            i_clk,
    input  wire  t_cell_op i_op,
    input  wire  t_cell_wr i_wr,
    output logic           o_dup,
    output t_value         o_rd_value
);

    t_value             w_entry [CAPACITY];
    t_value             w_acc   [CAPACITY];
    logic [CAPACITY-1:0] w_ge;
    logic [CAPACITY-1:0] w_eq;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_value w_left;
        t_value w_right;
        t_value w_acc_in;
        logic   w_left_ge;

        if (g == 0) begin : g_head
            assign w_left    = '0;
            assign w_left_ge = 1'b0;
            assign w_acc_in  = '0;
        end else begin : g_body
            assign w_left    = w_entry[g-1];
            assign w_left_ge = w_ge[g-1];
            assign w_acc_in  = w_acc[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = w_entry[g];
        end else begin : g_mid
            assign w_right = w_entry[g+1];
        end

        sse_cell u_cell (
            .i_clk         (i_clk),
            .i_index       (IDX_W'(g)),
            .i_op          (i_op),
            .i_wr          (i_wr),
            .i_left_entry  (w_left),
            .i_left_ge     (w_left_ge),
            .i_right_entry (w_right),
            .i_acc         (w_acc_in),
            .o_entry       (w_entry[g]),
            .o_ge          (w_ge[g]),
            .o_eq          (w_eq[g]),
            .o_acc         (w_acc[g])
        );
    end

    assign o_dup      = |w_eq;
    assign o_rd_value = w_acc[CAPACITY-1];

endmodule

`default_nettype wire

// ===== design/sorted_set_engine.sv =====
// sorted_set_engine: bounded sorted set of signed values held in a row of slots
// depends on sse_pkg and sse_chain (which holds the sse_cell row)
//
// usage
//   input channel s_axis_*: one operation per item. tuser carries the operation
//   (insert, delete at position, reverse order, read at position), tdata the
//   value to insert and the 1-based position.
//   output channel m_axis_*: exactly one result item per operation. tuser holds
//   the status (done, duplicate, full, bad position), tdata the value read or
//   deleted and the entry count after the operation.
//   the slots always hold the entries in ascending order; reverse only flips
//   the way positions are counted.
// timing
//   every operation completes in the cycle it is accepted: all slots compare
//   against the value at once and shift by one place together. the result is
//   registered in the output register, valid in the next cycle. throughput is
//   one item per cycle while m_axis_tready is high, set by the single output
//   register the next item may overwrite in the same cycle the result is taken.
// reset and stall
//   synchronous active-low reset empties the set, selects ascending order and
//   drops any pending result. while the receiver holds tready low, the result
//   stays put and s_axis_tready falls, so no item is accepted.
`default_nettype none

module sorted_set_engine
    import sse_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire  [S_DATA_W-1:0] s_axis_tdata,  // value[31:0], position[36:32], zero pad
    input  wire  [MODE_W-1:0]   s_axis_tuser,  // mode[1:0]
    output logic                m_axis_tvalid,
    input  wire                 m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,  // item_value[31:0], item_count[36:32], zero pad
    output logic [STATUS_W-1:0] m_axis_tuser   // status[1:0]
);

    // architectural state
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_desc;
    logic             n_desc;

    // output register
    logic               r_m_valid;
    t_status            r_status;
    t_status            n_status;
    logic [VALUE_W-1:0] r_item;
    logic [VALUE_W-1:0] n_item;
    logic [COUNT_W-1:0] r_item_count;

    // input fields
    t_op               w_mode;
    logic [VALUE_W-1:0] w_value_in;
    logic [POS_W-1:0]   w_pos;
    logic               w_accept;

    // position decode
    logic [CMP_W-1:0] w_pos_x;
    logic [CMP_W-1:0] w_count_x;
    logic [CMP_W-1:0] w_at_x;
    logic             w_pos_ok;
    logic             w_full;

    // row interface
    t_cell_op w_op;
    t_cell_wr w_wr;
    logic     w_dup;
    t_value   w_rd_value;

    assign w_mode     = t_op'(s_axis_tuser);
    assign w_value_in = s_axis_tdata[VALUE_W-1:0];
    assign w_pos      = s_axis_tdata[VALUE_W +: POS_W];

    // the output register frees up in the cycle its result is taken
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_pos_x   = CMP_W'(w_pos);
    assign w_count_x = CMP_W'(r_count);
    assign w_pos_ok  = (w_pos_x != '0) && (w_pos_x <= w_count_x);
    // descending order counts positions from the top of the ascending store
    assign w_at_x    = r_desc ? (w_count_x - w_pos_x) : (w_pos_x - CMP_W'(1));
    assign w_full    = (r_count == CNT_W'(CAPACITY));

    assign w_op.value = VALUE_BITS'($signed(w_value_in));
    assign w_op.count = r_count;
    assign w_op.at    = w_at_x[IDX_W-1:0];

    // duplicates win over the full check, so a full set still reports them
    assign w_wr.ins = w_accept && (w_mode == OP_INSERT) && !w_dup && !w_full;
    assign w_wr.del = w_accept && (w_mode == OP_DELETE) && w_pos_ok;

    sse_chain u_chain (
        .i_clk      (i_clk),
        .i_op       (w_op),
        .i_wr       (w_wr),
        .o_dup      (w_dup),
        .o_rd_value (w_rd_value)
    );

    // result and next state for the item being accepted
    always_comb begin
        n_status = ST_DONE;
        n_item   = '0;
        n_count  = r_count;
        n_desc   = r_desc;
        unique case (w_mode)
            OP_INSERT: begin
                if (w_dup) begin
                    n_status = ST_DUP;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_DELETE: begin
                if (w_pos_ok) begin
                    n_item  = VALUE_W'($signed(w_rd_value));
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_status = ST_BADPOS;
                end
            end
            OP_REVERSE: begin
                n_desc = !r_desc;
            end
            OP_READ: begin
                if (w_pos_ok) begin
                    n_item = VALUE_W'($signed(w_rd_value));
                end else begin
                    n_status = ST_BADPOS;
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_desc    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count   <= n_count;
                r_desc    <= n_desc;
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status     <= n_status;
            r_item       <= n_item;
            r_item_count <= COUNT_W'(n_count);
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = M_DATA_W'({r_item_count, r_item});

endmodule

`default_nettype wire

// ===== design/sse_checker.sv =====
// sse_checker: port-level checks on the sorted set engine, bound to the top level
// depends on sse_pkg and sorted_set_engine
`default_nettype none

module sse_checker
    import sse_pkg::*;
(
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 s_axis_tvalid,
    input wire                 s_axis_tready,
    input wire                 m_axis_tvalid,
    input wire                 m_axis_tready,
    input wire [M_DATA_W-1:0]  m_axis_tdata,
    input wire [STATUS_W-1:0]  m_axis_tuser
);

    // no pending result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // every accepted item leaves a result in the next cycle
    a_item_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted item gave no result");

    // a stalled result blocks the input side
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while result stalled");

    // a stalled result keeps its payload
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // a full report only comes with a full store
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_FULL)
        |-> (m_axis_tdata[VALUE_W +: COUNT_W] == COUNT_W'(CAPACITY)))
        else $error("full status with spare room");

endmodule

bind sorted_set_engine sse_checker u_sse_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== sim/sorted_set_checker.sv =====
// sorted_set_checker: watches both streams of the sorted set engine, keeps a
// mirror of the set, predicts each result item and compares it field by field
// depends on sse_pkg
`default_nettype none

module sorted_set_checker
    import sse_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_tvalid,
    input  wire                 i_s_tready,
    input  wire  [S_DATA_W-1:0] i_s_tdata,   // value[31:0], position[36:32], zero pad
    input  wire  [MODE_W-1:0]   i_s_tuser,   // mode[1:0]
    input  wire                 i_m_tvalid,
    input  wire                 i_m_tready,
    input  wire  [M_DATA_W-1:0] i_m_tdata,   // item_value[31:0], item_count[36:32], zero pad
    input  wire  [STATUS_W-1:0] i_m_tuser,   // status[1:0]
    output int                  o_fail_count,
    output int                  o_pending
);

    typedef struct packed {
        t_status              status;
        t_value               value;
        logic [COUNT_W-1:0]   count;
    } t_set_result;

    // mirror of the store: ascending, only the first mirror_count are valid
    t_value      mirror_entries [CAPACITY];
    int          mirror_count;
    bit          mirror_desc;

    t_set_result pending_results [$];
    t_set_result want;
    int          fails;

    t_status            got_status;
    t_value             got_value;
    logic [COUNT_W-1:0] got_count;

    initial begin
        fails        = 0;
        mirror_count = 0;
        mirror_desc  = 1'b0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    // store index of a 1-based position in the current order, -1 if out of range
    function automatic int presented_index(logic [POS_W-1:0] pos);
        if (pos == 0 || int'(pos) > mirror_count)
            return -1;
        if (mirror_desc)
            return mirror_count - int'(pos);
        return int'(pos) - 1;
    endfunction

    // applies one operation to the mirror and returns the result it gives
    function automatic t_set_result next_set_result(t_op op, t_value v, logic [POS_W-1:0] pos);
        t_set_result r;
        int          slot;
        int          at;
        int          i;
        r.status = ST_DONE;
        r.value  = '0;
        case (op)
            OP_INSERT: begin
                slot = mirror_count;
                for (i = mirror_count - 1; i >= 0; i--)
                    if (mirror_entries[i] >= v)
                        slot = i;
                if (slot < mirror_count && mirror_entries[slot] == v) begin
                    r.status = ST_DUP;
                end else if (mirror_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = mirror_count; i > slot; i--)
                        mirror_entries[i] = mirror_entries[i - 1];
                    mirror_entries[slot] = v;
                    mirror_count++;
                end
            end
            OP_DELETE: begin
                at = presented_index(pos);
                if (at < 0) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.value = mirror_entries[at];
                    for (i = at; i + 1 < mirror_count; i++)
                        mirror_entries[i] = mirror_entries[i + 1];
                    mirror_count--;
                end
            end
            OP_REVERSE: begin
                mirror_desc = !mirror_desc;
            end
            default: begin
                at = presented_index(pos);
                if (at < 0)
                    r.status = ST_BADPOS;
                else
                    r.value = mirror_entries[at];
            end
        endcase
        r.count = COUNT_W'(mirror_count);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mirror_count = 0;
            mirror_desc  = 1'b0;
            pending_results.delete();
        end else begin
            // expectation first, so a same-edge result still finds it queued
            if (i_s_tvalid && i_s_tready)
                pending_results.push_back(next_set_result(t_op'(i_s_tuser),
                    t_value'(i_s_tdata[VALUE_W-1:0]), i_s_tdata[VALUE_W +: POS_W]));
            if (i_m_tvalid && i_m_tready) begin
                got_status = t_status'(i_m_tuser);
                got_value  = t_value'(i_m_tdata[VALUE_W-1:0]);
                got_count  = i_m_tdata[VALUE_W +: COUNT_W];
                if (pending_results.size() == 0) begin
                    $error("result item with no operation outstanding");
                    fails++;
                end else begin
                    want = pending_results.pop_front();
                    if (got_status != want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got_status);
                        fails++;
                    end
                    if (got_value != want.value) begin
                        $error("item_value: expected %0d, got %0d", want.value, got_value);
                        fails++;
                    end
                    if (got_count != want.count) begin
                        $error("item_count: expected %0d, got %0d", want.count, got_count);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= pending_results.size();
        o_fail_count <= fails;
    end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// testbench: drives operation items into the sorted set engine under random
// back-pressure and gives the verdict from the checker's failure count
// depends on sse_pkg, sorted_set_engine and sorted_set_checker
`default_nettype none

module testbench;
    import sse_pkg::*;

    localparam int QUIET_LIMIT = 3000;   // cycles with no item moving on either side
    localparam int HOLD_CYCLES = 300;    // long receiver hold-off

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    wire                 s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;   // value[31:0], position[36:32], zero pad
    logic [MODE_W-1:0]   s_axis_tuser;   // mode[1:0]
    wire                 m_axis_tvalid;
    logic                m_axis_tready;
    wire  [M_DATA_W-1:0] m_axis_tdata;   // item_value[31:0], item_count[36:32], zero pad
    wire  [STATUS_W-1:0] m_axis_tuser;   // status[1:0]

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_request;
    int quiet_cycles;

    sorted_set_engine uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    sorted_set_checker watch (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // receiver: random tready, or a long hold-off when asked; controls are
    // sampled at the rising edge and tready changes at the falling edge
    initial begin : receiver
        int  pct;
        bit  hold_now;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge clk);
            pct      = recv_idle_pct;
            hold_now = hold_request;
            if (hold_now)
                hold_request = 1'b0;
            @(negedge clk);
            if (hold_now) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= pct);
            end
        end
    end

    // watchdog: ends the run if nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // many small values so duplicates turn up, some extremes, rest anything
    function automatic t_value pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return t_value'(int'($urandom_range(15)) - 8);
        if (r < 48) begin
            case ($urandom_range(3))
                0:       return t_value'(32'h7FFF_FFFF);
                1:       return t_value'(32'h8000_0000);
                2:       return t_value'(0);
                default: return t_value'(-1);
            endcase
        end
        return t_value'($urandom);
    endfunction

    // mostly in range, some zero, some past the capacity
    function automatic logic [POS_W-1:0] pick_pos();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return POS_W'($urandom_range(16, 1));
        if (r < 88)
            return '0;
        return POS_W'($urandom_range(31, 17));
    endfunction

    // burst flavours: fill the set, drain it, or a mix
    function automatic t_op pick_op(int kind);
        int r;
        r = $urandom_range(99);
        case (kind)
            0: begin
                if (r < 85) return OP_INSERT;
                if (r < 90) return OP_DELETE;
                if (r < 95) return OP_READ;
                return OP_REVERSE;
            end
            1: begin
                if (r < 65) return OP_DELETE;
                if (r < 85) return OP_READ;
                if (r < 92) return OP_REVERSE;
                return OP_INSERT;
            end
            default: begin
                if (r < 35) return OP_INSERT;
                if (r < 60) return OP_DELETE;
                if (r < 90) return OP_READ;
                return OP_REVERSE;
            end
        endcase
    endfunction

    // offers one item from a falling edge, returns at the falling edge after
    // it is taken; tvalid stays high between back-to-back items
    task automatic offer(input t_op op, input t_value v, input logic [POS_W-1:0] pos);
        logic [S_DATA_W-1:0] word;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        word = '0;
        word[VALUE_W-1:0]     = v;
        word[VALUE_W +: POS_W] = pos;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= word;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic random_phase(input int n);
        int sent;
        int kind;
        int len;
        int j;
        sent = 0;
        while (sent < n) begin
            kind = $urandom_range(2);
            len  = $urandom_range(24, 8);
            for (j = 0; j < len && sent < n; j++) begin
                offer(pick_op(kind), pick_value(), pick_pos());
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_INSERT;
        send_idle_pct = 22;
        recv_idle_pct = 61;
        hold_request  = 1'b0;
        quiet_cycles  = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty store, extremes, duplicate, bad positions
        offer(OP_READ,    t_value'($urandom), 5'd1);
        offer(OP_DELETE,  t_value'($urandom), 5'd0);
        offer(OP_REVERSE, t_value'($urandom), 5'd0);   // flag toggles on an empty set
        offer(OP_REVERSE, t_value'($urandom), 5'd3);
        offer(OP_INSERT,  t_value'(32'h7FFF_FFFF), 5'd0);
        offer(OP_INSERT,  t_value'(32'h8000_0000), 5'd31);
        offer(OP_INSERT,  t_value'(0), 5'd0);
        offer(OP_INSERT,  t_value'(-1), 5'd0);
        offer(OP_INSERT,  t_value'(1), 5'd0);
        offer(OP_INSERT,  t_value'(0), 5'd0);          // duplicate
        offer(OP_READ,    t_value'($urandom), 5'd0);
        offer(OP_READ,    t_value'($urandom), 5'd1);
        offer(OP_READ,    t_value'($urandom), 5'd5);
        offer(OP_READ,    t_value'($urandom), 5'd6);
        offer(OP_READ,    t_value'($urandom), 5'd31);
        // descending order: head and tail deletes, insert after reverse
        offer(OP_REVERSE, t_value'($urandom), 5'd0);
        offer(OP_READ,    t_value'($urandom), 5'd1);
        offer(OP_INSERT,  t_value'(100), 5'd0);
        offer(OP_READ,    t_value'($urandom), 5'd2);
        offer(OP_DELETE,  t_value'($urandom), 5'd1);
        offer(OP_DELETE,  t_value'($urandom), 5'd5);
        offer(OP_DELETE,  t_value'($urandom), 5'd6);
        offer(OP_REVERSE, t_value'($urandom), 5'd0);
        offer(OP_DELETE,  t_value'($urandom), 5'd2);

        random_phase(330);

        send_idle_pct = 61;
        recv_idle_pct = 22;
        random_phase(330);

        // no idling; the receiver holds off for a while to fill the block
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        random_phase(340);

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/sse_pkg.sv
design/sse_cell.sv
design/sse_chain.sv
design/sorted_set_engine.sv
design/sse_checker.sv
sim/sorted_set_checker.sv
sim/testbench.sv
